// ===== rtl/ata_chs_command_issuer_unit_assert.svh =====
// assertion macros shared by the command issuer rtl
// needs nothing else; files that check their logic take it by include
`ifndef ATA_CHS_COMMAND_ISSUER_UNIT_ASSERT_SVH
`define ATA_CHS_COMMAND_ISSUER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ACCI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ACCI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/acci_pkg.sv =====
// shared types, codes and sizes of the ata chs command issuer
// no dependencies
`default_nettype none

package acci_pkg;

   // address width and divider sizing
   localparam int LBA_BITS    = 28;
   localparam int DIV_CYCLES  = (LBA_BITS + 1) / 2;
   localparam int DIV_W       = 2 * DIV_CYCLES;
   localparam int CNT_W       = $clog2(DIV_CYCLES);
   localparam int PER_CYL_W   = 13;
   localparam int CAP_W       = 29;
   localparam int CMP_W       = (LBA_BITS > CAP_W) ? LBA_BITS : CAP_W;
   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam logic [2:0] CSR_HEAD_COUNT   = 3'd0;
   localparam logic [2:0] CSR_SECTORS      = 3'd1;
   localparam logic [2:0] CSR_CYLINDERS    = 3'd2;
   localparam logic [2:0] CSR_READ_OPCODE  = 3'd3;
   localparam logic [2:0] CSR_WRITE_OPCODE = 3'd4;

   // request kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;

   // result status codes
   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_INVALID_BLOCK = 2'd1;
   localparam logic [1:0] ST_BAD_COMMAND   = 2'd2;

   // task file register offsets
   localparam logic [2:0] OFF_NONE      = 3'd0;
   localparam logic [2:0] OFF_COUNT     = 3'd2;
   localparam logic [2:0] OFF_SECTOR    = 3'd3;
   localparam logic [2:0] OFF_CYL_LOW   = 3'd4;
   localparam logic [2:0] OFF_CYL_HIGH  = 3'd5;
   localparam logic [2:0] OFF_DRIVE_HD  = 3'd6;
   localparam logic [2:0] OFF_COMMAND   = 3'd7;

   localparam logic [7:0] DRIVE_HEAD_BASE = 8'hA0;

   // geometry used by the back end divider
   typedef struct packed {
      logic [4:0] head_count;
      logic [7:0] sectors_per_track;
   } geo_type;

   // classified request held in the queue
   typedef struct packed {
      logic [1:0]          status;
      logic [LBA_BITS-1:0] lba;
      logic [7:0]          count;
      logic [7:0]          opcode;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/acci_front.sv =====
// front end: configuration registers, capacity, request classification
// depends on acci_pkg
`default_nettype none

module acci_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [acci_pkg::LBA_BITS-1:0] req_block_address,
   input  wire logic [1:0]                  req_kind,
   input  wire logic [7:0]                  req_sector_count,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [15:0]                 csr_data,
   input  wire logic                        queue_full,
   output logic                             queue_push,
   output acci_pkg::cmd_type                queue_cmd,
   output acci_pkg::geo_type                geo
);

   logic [4:0]  head_count_ff, head_count_in;
   logic [7:0]  spt_ff, spt_in;
   logic [15:0] cyl_count_ff, cyl_count_in;
   logic [7:0]  rd_opcode_ff, rd_opcode_in;
   logic [7:0]  wr_opcode_ff, wr_opcode_in;
   logic [acci_pkg::PER_CYL_W-1:0] per_cyl_ff, per_cyl_in;
   logic [acci_pkg::CAP_W-1:0]     capacity_ff, capacity_in;
   logic [1:0]  settle_ff, settle_in;
   logic        csr_write;
   logic        req_accept;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // configuration register writes
   always_comb begin
      head_count_in = head_count_ff;
      spt_in        = spt_ff;
      cyl_count_in  = cyl_count_ff;
      rd_opcode_in  = rd_opcode_ff;
      wr_opcode_in  = wr_opcode_ff;
      if (csr_write) begin
         unique case (csr_index)
            acci_pkg::CSR_HEAD_COUNT:   head_count_in = csr_data[4:0];
            acci_pkg::CSR_SECTORS:      spt_in        = csr_data[7:0];
            acci_pkg::CSR_CYLINDERS:    cyl_count_in  = csr_data;
            acci_pkg::CSR_READ_OPCODE:  rd_opcode_in  = csr_data[7:0];
            acci_pkg::CSR_WRITE_OPCODE: wr_opcode_in  = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // capacity in two registered multiplies
   assign per_cyl_in  = acci_pkg::PER_CYL_W'(head_count_ff) * acci_pkg::PER_CYL_W'(spt_ff);
   assign capacity_in = acci_pkg::CAP_W'(per_cyl_ff) * acci_pkg::CAP_W'(cyl_count_ff);

   // hold off requests until the capacity reflects the latest geometry
   always_comb begin
      settle_in = settle_ff;
      if (csr_write) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   assign req_stall  = queue_full | csr_valid | (settle_ff != 2'd0);
   assign req_accept = req_valid & ~req_stall;

   // classify: address range first, then kind
   always_comb begin
      queue_cmd.lba    = req_block_address;
      queue_cmd.count  = req_sector_count;
      queue_cmd.opcode = rd_opcode_ff;
      queue_cmd.status = acci_pkg::ST_OK;
      priority if (acci_pkg::CMP_W'(req_block_address) >= acci_pkg::CMP_W'(capacity_ff)) begin
         queue_cmd.status = acci_pkg::ST_INVALID_BLOCK;
      end else if (req_kind == acci_pkg::KIND_READ) begin
         queue_cmd.opcode = rd_opcode_ff;
      end else if (req_kind == acci_pkg::KIND_WRITE) begin
         queue_cmd.opcode = wr_opcode_ff;
      end else begin
         queue_cmd.status = acci_pkg::ST_BAD_COMMAND;
      end
   end

   assign queue_push            = req_accept;
   assign geo.head_count        = head_count_ff;
   assign geo.sectors_per_track = spt_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_count_ff <= 5'd16;
         spt_ff        <= 8'd63;
         cyl_count_ff  <= 16'd1024;
         rd_opcode_ff  <= 8'h20;
         wr_opcode_ff  <= 8'h30;
         settle_ff     <= 2'd2;
      end else begin
         head_count_ff <= head_count_in;
         spt_ff        <= spt_in;
         cyl_count_ff  <= cyl_count_in;
         rd_opcode_ff  <= rd_opcode_in;
         wr_opcode_ff  <= wr_opcode_in;
         settle_ff     <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      per_cyl_ff  <= per_cyl_in;
      capacity_ff <= capacity_in;
   end

endmodule

`default_nettype wire

// ===== rtl/acci_queue.sv =====
// short queue of classified requests between front and back end
// depends on acci_pkg and the assertion macro header
`default_nettype none

`include "ata_chs_command_issuer_unit_assert.svh"

module acci_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire acci_pkg::cmd_type push_cmd,
   output logic                   full,
   output logic                   pop_valid,
   output acci_pkg::cmd_type      pop_cmd,
   input  wire logic              pop
);

   localparam int PTR_W = (acci_pkg::QUEUE_DEPTH > 1) ? $clog2(acci_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(acci_pkg::QUEUE_DEPTH + 1);

   acci_pkg::cmd_type  entry_ff [acci_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   assign full      = (fill_ff == FILL_W'(acci_pkg::QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(acci_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(acci_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // no push into a full queue, no pop from an empty one, fill within depth
   `ACCI_ASSERT_IMP(a_no_overflow, clock, reset, push, !full, "queue push while full")
   `ACCI_ASSERT_IMP(a_no_underflow, clock, reset, pop, pop_valid, "queue pop while empty")
   `ACCI_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= FILL_W'(acci_pkg::QUEUE_DEPTH), "queue fill count out of range")

endmodule

`default_nettype wire

// ===== rtl/acci_back.sv =====
// back end: chs conversion by a shared radix-4 divider, then task file writes
// depends on acci_pkg and the assertion macro header
`default_nettype none

`include "ata_chs_command_issuer_unit_assert.svh"

module acci_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire acci_pkg::geo_type geo,
   input  wire logic              cmd_valid,
   input  wire acci_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_reg_offset,
   output logic [7:0]             rsp_reg_data,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV1 = 2'd1;
   localparam logic [1:0] S_DIV2 = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;
   localparam logic [2:0] LAST_IDX = 3'd5;

   // one restoring step: returns {quotient bit, remainder}
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic din,
                                           input logic [7:0] divisor);
      logic [8:0] t;
      logic [8:0] d;
      begin
         t = {rem, din};
         d = {1'b0, divisor};
         if (t >= d) begin
            div_step = {1'b1, 8'(t - d)};
         end else begin
            div_step = {1'b0, t[7:0]};
         end
      end
   endfunction

   logic [1:0]                 state_ff, state_in;
   logic [acci_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                 rem_ff, rem_in;
   logic [acci_pkg::DIV_W-1:0] work_ff, work_in;
   logic [7:0]                 sect_ff, sect_in;
   logic [7:0]                 count_ff, count_in;
   logic [7:0]                 opcode_ff, opcode_in;
   logic [1:0]                 err_ff, err_in;
   logic [2:0]                 idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 off_ff, off_in;
   logic [7:0]                 data_ff, data_in;
   logic [1:0]                 status_ff, status_in;
   logic                       last_ff, last_in;

   logic [7:0]                 divisor;
   logic [8:0]                 step1, step2;
   logic [acci_pkg::DIV_W-1:0] work_shift;
   logic                       out_load;
   logic                       emit_last;

   // two divider steps per cycle
   assign divisor    = (state_ff == S_DIV1) ? geo.sectors_per_track : {3'b000, geo.head_count};
   assign step1      = div_step(rem_ff, work_ff[acci_pkg::DIV_W-1], divisor);
   assign step2      = div_step(step1[7:0], work_ff[acci_pkg::DIV_W-2], divisor);
   assign work_shift = {work_ff[acci_pkg::DIV_W-3:0], step1[8], step2[8]};

   assign out_load  = ~rsp_valid_ff | ~rsp_stall;
   assign emit_last = (err_ff != acci_pkg::ST_OK) || (idx_ff == LAST_IDX);
   assign cmd_pop   = (state_ff == S_IDLE) & cmd_valid;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      work_in   = work_ff;
      sect_in   = sect_ff;
      count_in  = count_ff;
      opcode_in = opcode_ff;
      err_in    = err_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               count_in  = cmd.count;
               opcode_in = cmd.opcode;
               err_in    = cmd.status;
               idx_in    = 3'd0;
               rem_in    = 8'd0;
               work_in   = acci_pkg::DIV_W'(cmd.lba);
               cnt_in    = acci_pkg::CNT_W'(acci_pkg::DIV_CYCLES - 1);
               state_in  = (cmd.status == acci_pkg::ST_OK) ? S_DIV1 : S_EMIT;
            end
         end
         S_DIV1: begin
            work_in = work_shift;
            rem_in  = step2[7:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // sector from the remainder, quotient becomes next dividend
               sect_in  = step2[7:0] + 8'd1;
               rem_in   = 8'd0;
               cnt_in   = acci_pkg::CNT_W'(acci_pkg::DIV_CYCLES - 1);
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            work_in = work_shift;
            rem_in  = step2[7:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_load) begin
               idx_in = idx_ff + 3'd1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register, loaded with the current task file write
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      off_in       = off_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      if (out_load) begin
         rsp_valid_in = (state_ff == S_EMIT);
         status_in    = err_ff;
         last_in      = emit_last;
         if (err_ff != acci_pkg::ST_OK) begin
            off_in  = acci_pkg::OFF_NONE;
            data_in = 8'd0;
         end else begin
            unique case (idx_ff)
               3'd0: begin
                  off_in  = acci_pkg::OFF_COUNT;
                  data_in = count_ff;
               end
               3'd1: begin
                  off_in  = acci_pkg::OFF_SECTOR;
                  data_in = sect_ff;
               end
               3'd2: begin
                  off_in  = acci_pkg::OFF_CYL_LOW;
                  data_in = work_ff[7:0];
               end
               3'd3: begin
                  off_in  = acci_pkg::OFF_CYL_HIGH;
                  data_in = work_ff[15:8];
               end
               3'd4: begin
                  off_in  = acci_pkg::OFF_DRIVE_HD;
                  data_in = acci_pkg::DRIVE_HEAD_BASE | rem_ff;
               end
               default: begin
                  off_in  = acci_pkg::OFF_COMMAND;
                  data_in = opcode_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      work_ff   <= work_in;
      sect_ff   <= sect_in;
      count_ff  <= count_in;
      opcode_ff <= opcode_in;
      err_ff    <= err_in;
      idx_ff    <= idx_in;
      off_ff    <= off_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_offset = off_ff;
   assign rsp_reg_data   = data_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

   // error results are single and final; good requests end on the command write
   `ACCI_ASSERT_IMP(a_err_single, clock, reset,
      rsp_valid_ff && status_ff != acci_pkg::ST_OK, last_ff && off_ff == acci_pkg::OFF_NONE,
      "error result not final")
   `ACCI_ASSERT_IMP(a_ok_last_cmd, clock, reset,
      rsp_valid_ff && status_ff == acci_pkg::ST_OK && last_ff, off_ff == acci_pkg::OFF_COMMAND,
      "final ok result is not the command write")
   `ACCI_ASSERT_NXT(a_div2_exit, clock, reset,
      state_ff == S_DIV2, state_ff == S_DIV2 || state_ff == S_EMIT,
      "second division left to a wrong state")

endmodule

`default_nettype wire

// ===== rtl/ata_chs_command_issuer_unit.sv =====
// top level of the ata chs command issuer: front end, queue, back end
// depends on acci_pkg, acci_front, acci_queue, acci_back
//
// channel   dir   handshake            carries
// req_      in    req_valid/req_stall  block_address, kind, sector_count
// rsp_      out   rsp_valid/rsp_stall  reg_offset, reg_data, status, last
// csr_      in    csr_valid/csr_ready  index, data (16 bits)
//
// a good request runs the back end divider twice, two quotient bits a cycle,
// then issues six task file writes; an invalid or bad request skips the
// divider and gives a single result. the front end accepts a request a cycle
// while the two-entry queue has room, no register write is offered and,
// after reset or a register write, the capacity reflects the latest geometry.
// a stalled result holds in the output register; the back end waits to emit.
`default_nettype none

module ata_chs_command_issuer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [acci_pkg::LBA_BITS-1:0] req_block_address,
   input  wire logic [1:0]                    req_kind,
   input  wire logic [7:0]                    req_sector_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_reg_offset,
   output logic [7:0]                         rsp_reg_data,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [15:0]                   csr_data
);

   logic               queue_full;
   logic               queue_push;
   acci_pkg::cmd_type  push_cmd;
   logic               pop_valid;
   acci_pkg::cmd_type  pop_cmd;
   logic               queue_pop;
   acci_pkg::geo_type  geo;

   // accept and classify
   acci_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_block_address (req_block_address),
      .req_kind          (req_kind),
      .req_sector_count  (req_sector_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_cmd         (push_cmd),
      .geo               (geo)
   );

   // decoupling queue
   acci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (queue_pop)
   );

   // convert and issue
   acci_back u_back (
      .clock          (clock),
      .reset          (reset),
      .geo            (geo),
      .cmd_valid      (pop_valid),
      .cmd            (pop_cmd),
      .cmd_pop        (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_offset (rsp_reg_offset),
      .rsp_reg_data   (rsp_reg_data),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the ata chs command issuer: directed and random block requests
// checked against an in-bench task file predictor; depends on acci_pkg and the rtl
`timescale 1ns / 1ps

import acci_pkg::*;

// one task file register write as it leaves the block
typedef struct packed {
   logic [2:0] offset;
   logic [7:0] data;
   logic [1:0] status;
   logic       last;
} tf_write_type;

// geometry copy, task file predictor and queue of writes still to arrive
class task_file_tracker;
   logic [4:0]   head_count;
   logic [7:0]   sectors_per_track;
   logic [15:0]  cylinder_count;
   logic [7:0]   read_opcode;
   logic [7:0]   write_opcode;
   tf_write_type pending_writes[$];
   int           mismatches;

   function new();
      head_count        = 5'd16;
      sectors_per_track = 8'd63;
      cylinder_count    = 16'd1024;
      read_opcode       = 8'h20;
      write_opcode      = 8'h30;
      mismatches        = 0;
   endfunction

   // register write as the block sees it, spare indexes dropped
   function void apply_csr(logic [2:0] index, logic [15:0] data);
      case (index)
         CSR_HEAD_COUNT:   head_count        = data[4:0];
         CSR_SECTORS:      sectors_per_track = data[7:0];
         CSR_CYLINDERS:    cylinder_count    = data;
         CSR_READ_OPCODE:  read_opcode       = data[7:0];
         CSR_WRITE_OPCODE: write_opcode      = data[7:0];
         default: ;
      endcase
   endfunction

   function longint unsigned capacity();
      return longint'(head_count) * longint'(sectors_per_track) * longint'(cylinder_count);
   endfunction

   function void push_write(logic [2:0] offset, logic [7:0] data, logic [1:0] status,
                            logic last);
      tf_write_type w;
      w.offset = offset;
      w.data   = data;
      w.status = status;
      w.last   = last;
      pending_writes.push_back(w);
   endfunction

   // lba to chs conversion and the six register writes of one request
   function void note_request(logic [LBA_BITS-1:0] lba, logic [1:0] kind, logic [7:0] count);
      longint unsigned per_cyl;
      longint unsigned lba_w;
      longint unsigned cyl;
      logic [7:0]      opcode;
      logic [7:0]      sector;
      logic [7:0]      head;
      per_cyl = longint'(head_count) * longint'(sectors_per_track);
      lba_w   = longint'(lba);
      // address check wins over the kind check; zero geometry lands here too
      if (lba_w >= capacity()) begin
         push_write(OFF_NONE, 8'd0, ST_INVALID_BLOCK, 1'b1);
         return;
      end
      if (kind == KIND_READ) begin
         opcode = read_opcode;
      end else if (kind == KIND_WRITE) begin
         opcode = write_opcode;
      end else begin
         push_write(OFF_NONE, 8'd0, ST_BAD_COMMAND, 1'b1);
         return;
      end
      sector = 8'(lba_w % sectors_per_track + 1);
      head   = 8'((lba_w / sectors_per_track) % head_count);
      cyl    = (lba_w / per_cyl) & 64'hFFFF;
      push_write(OFF_COUNT, count, ST_OK, 1'b0);
      push_write(OFF_SECTOR, sector, ST_OK, 1'b0);
      push_write(OFF_CYL_LOW, 8'(cyl), ST_OK, 1'b0);
      push_write(OFF_CYL_HIGH, 8'(cyl >> 8), ST_OK, 1'b0);
      push_write(OFF_DRIVE_HD, DRIVE_HEAD_BASE | head, ST_OK, 1'b0);
      push_write(OFF_COMMAND, opcode, ST_OK, 1'b1);
   endfunction

   task report(string what);
      mismatches++;
      $display("mismatch: %s", what);
   endtask

   // compare one accepted result with the oldest predicted write
   task check_write(logic [2:0] offset, logic [7:0] data, logic [1:0] status, logic last);
      tf_write_type want;
      if (pending_writes.size() == 0) begin
         report($sformatf("unexpected result offset %0d data %02h status %0d last %0b",
                          offset, data, status, last));
         return;
      end
      want = pending_writes.pop_front();
      if (offset !== want.offset)
         report($sformatf("reg_offset %0d, want %0d", offset, want.offset));
      if (data !== want.data)
         report($sformatf("reg_data %02h, want %02h (offset %0d)", data, want.data,
                          want.offset));
      if (status !== want.status)
         report($sformatf("status %0d, want %0d", status, want.status));
      if (last !== want.last)
         report($sformatf("last %0b, want %0b (offset %0d)", last, want.last, want.offset));
   endtask
endclass

module tb;
   localparam int              CYCLE_LIMIT      = 400000;
   localparam int              SETTLE_CYCLES    = 60;
   localparam longint unsigned LBA_SPAN         = 64'd1 << LBA_BITS;
   localparam logic [LBA_BITS-1:0] LBA_MAX      = '1;
   localparam logic [1:0]      KIND_RESERVED_LO = 2'd2;
   localparam logic [1:0]      KIND_RESERVED_HI = 2'd3;
   localparam logic [2:0]      CSR_SPARE_FIRST  = 3'd5;
   localparam logic [2:0]      CSR_SPARE_LAST   = 3'd7;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [LBA_BITS-1:0] req_block_address;
   logic [1:0]          req_kind;
   logic [7:0]          req_sector_count;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [2:0]          rsp_reg_offset;
   logic [7:0]          rsp_reg_data;
   logic [1:0]          rsp_status;
   logic                rsp_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [2:0]          csr_index;
   logic [15:0]         csr_data;

   task_file_tracker tracker = new();
   bit               send_quiet;
   bit               accept_quiet;
   int               stall_left;
   int               cycle_count;

   ata_chs_command_issuer_unit dut (.*);

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result side back-pressure: a fresh stall length after every transaction
   always @(posedge clock) begin : result_stall
      int hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold = accept_quiet ? 0 : int'($urandom_range(0, 14));
         rsp_stall  <= (hold != 0);
         stall_left <= hold;
      end else if (stall_left > 0) begin
         rsp_stall  <= (stall_left > 1);
         stall_left <= stall_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_write(rsp_reg_offset, rsp_reg_data, rsp_status, rsp_last);
   end

   task automatic send_request(logic [LBA_BITS-1:0] address, logic [1:0] kind,
                               logic [7:0] count);
      int gap;
      gap = send_quiet ? 0 : int'($urandom_range(0, 14));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_block_address <= address;
      req_kind          <= kind;
      req_sector_count  <= count;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(address, kind, count);
   endtask

   // stop sending and let every predicted write come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (tracker.pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.apply_csr(index, data);
   endtask

   task automatic set_geometry(logic [15:0] heads, logic [15:0] sectors, logic [15:0] cyls,
                               logic [15:0] rd_op, logic [15:0] wr_op);
      write_csr(CSR_HEAD_COUNT, heads);
      write_csr(CSR_SECTORS, sectors);
      write_csr(CSR_CYLINDERS, cyls);
      write_csr(CSR_READ_OPCODE, rd_op);
      write_csr(CSR_WRITE_OPCODE, wr_op);
      csr_valid <= 1'b0;
   endtask

   // mostly in-range addresses, some near the capacity edge, some anywhere
   task automatic send_random_request();
      longint unsigned     cap;
      longint unsigned     top;
      logic [LBA_BITS-1:0] address;
      logic [1:0]          kind;
      int                  pick;
      int                  k;
      cap  = tracker.capacity();
      top  = (cap > LBA_SPAN) ? LBA_SPAN : cap;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, 2);
      if (pick < 10 || cap == 0)
         address = LBA_BITS'($urandom);
      else if (pick < 18 && cap < LBA_SPAN)
         address = LBA_BITS'(cap + longint'(k));
      else if (pick < 26)
         address = (longint'(k) < top) ? LBA_BITS'(top - 1 - longint'(k)) : '0;
      else
         address = LBA_BITS'($urandom_range(0, 32'(top - 1)));
      if ($urandom_range(0, 99) < 85)
         kind = ($urandom_range(0, 1) == 0) ? KIND_READ : KIND_WRITE;
      else
         kind = ($urandom_range(0, 1) == 0) ? KIND_RESERVED_LO : KIND_RESERVED_HI;
      send_request(address, kind, 8'($urandom));
      // occasionally hold off until the block has fully drained
      if ($urandom_range(0, 24) == 0)
         wait_for_results();
   endtask

   task automatic run_phase(int items);
      send_quiet   = ($urandom_range(0, 4) == 0);
      accept_quiet = ($urandom_range(0, 4) == 0);
      repeat (items) send_random_request();
      wait_for_results();
      send_quiet   = 1'b0;
      accept_quiet = 1'b0;
   endtask

   task automatic set_random_geometry();
      set_geometry((16'($urandom) & 16'hFFE0) | 16'($urandom_range(1, 31)),
                   (16'($urandom) & 16'hFF00) | 16'($urandom_range(1, 255)),
                   16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom));
   endtask

   // watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_block_address = '0;
      req_kind          = KIND_READ;
      req_sector_count  = 8'd0;
      csr_valid         = 1'b0;
      csr_index         = CSR_HEAD_COUNT;
      csr_data          = 16'd0;
      send_quiet        = 1'b0;
      accept_quiet      = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: 16 heads, 63 sectors, 1024 cylinders
      send_request(28'd0, KIND_READ, 8'd1);
      send_request(28'd0, KIND_WRITE, 8'd0);
      send_request(28'd62, KIND_READ, 8'd255);
      send_request(28'd63, KIND_READ, 8'd7);
      send_request(28'd1007, KIND_WRITE, 8'd128);
      send_request(28'd1008, KIND_READ, 8'd1);
      send_request(28'd258048, KIND_WRITE, 8'd2);
      send_request(28'd1032191, KIND_READ, 8'd255);
      send_request(28'd1032192, KIND_READ, 8'd1);
      send_request(LBA_MAX, KIND_WRITE, 8'd1);
      send_request(28'd5, KIND_RESERVED_LO, 8'd3);
      send_request(28'd5, KIND_RESERVED_HI, 8'd3);
      send_request(28'd1032192, KIND_RESERVED_HI, 8'd3);
      wait_for_results();
      run_phase(30);

      // large geometry within the address width, extreme opcodes
      set_geometry(16'd16, 16'd255, 16'hFFFF, 16'h00FF, 16'h0000);
      send_request(28'd267386879, KIND_WRITE, 8'd255);
      send_request(28'd267386880, KIND_READ, 8'd1);
      send_request(LBA_MAX, KIND_READ, 8'd0);
      wait_for_results();
      run_phase(30);

      // spare register indexes are ignored; then a one-sector disk
      for (int i = CSR_SPARE_FIRST; i <= CSR_SPARE_LAST; i++)
         write_csr(3'(i), 16'($urandom));
      set_geometry(16'd1, 16'd1, 16'd1, 16'h0000, 16'h00FF);
      send_request(28'd0, KIND_READ, 8'd9);
      send_request(28'd1, KIND_WRITE, 8'd9);
      wait_for_results();
      run_phase(20);

      // head count above sixteen, upper data bits dropped
      set_geometry(16'hFFFF, 16'($urandom_range(1, 255)), 16'($urandom),
                   16'($urandom), 16'($urandom));
      run_phase(35);

      // head count masks to zero: nothing is addressable
      set_geometry(16'h0020, 16'd7, 16'd100, 16'h0020, 16'h0030);
      run_phase(15);

      repeat (3) begin
         set_random_geometry();
         run_phase(35);
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/acci_pkg.sv
rtl/acci_front.sv
rtl/acci_queue.sv
rtl/acci_back.sv
rtl/ata_chs_command_issuer_unit.sv
verif/tb.sv
